// File: design/ap2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_pkg
// Shared types and constants of the streaming 2D average pooling block.
// ----------------------------------------------------------------------------
package ap2d_pkg;

  localparam int MaxWidth    = 256;
  localparam int MaxWindow   = 8;
  localparam int MaxChannels = 16;
  localparam int RowLimit    = 4096;
  localparam int StoreDepth  = MaxWindow * MaxWidth * MaxChannels;
  localparam int StoreAw     = $clog2(StoreDepth);

  localparam logic [2:0] CFG_IMAGE_HEIGHT  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_WIDTH   = 3'd1;
  localparam logic [2:0] CFG_CHANNEL_COUNT = 3'd2;
  localparam logic [2:0] CFG_WINDOW_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_WINDOW_WIDTH  = 3'd4;
  localparam logic [2:0] CFG_STRIDE_HEIGHT = 3'd5;
  localparam logic [2:0] CFG_STRIDE_WIDTH  = 3'd6;
  localparam logic [2:0] CFG_PADS          = 3'd7;

  typedef logic signed [15:0] pos_t;

  typedef struct packed {
    logic [12:0] h;
    logic [8:0]  w;
    logic [4:0]  ch;
    logic [3:0]  wh;
    logic [3:0]  ww;
    logic [3:0]  sh;
    logic [3:0]  sw;
    logic [2:0]  pt;
    logic [2:0]  pl;
    logic        ok;
    pos_t        trow;
    pos_t        tcol;
  } cfg_t;

  typedef struct packed {
    logic        ok;
    logic        frame_end;
    logic [15:0] sample;
    logic [2:0]  r3;
    logic [7:0]  x8;
    logic [3:0]  c4;
    logic        row_any;
    logic        row_multi;
    pos_t        row_o;
    pos_t        row_s;
    logic        col_any;
    logic        col_multi;
    pos_t        col_o;
    pos_t        col_s;
  } job_t;

  typedef struct packed {
    logic [15:0] average;
    logic [11:0] row;
    logic [7:0]  col;
    logic [3:0]  chan;
    logic        last;
    logic        frame_done;
    logic        err;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_WIN, S_RD, S_ACC, S_DIV, S_PUSH
  } state_t;

endpackage

// File: design/ap2d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_front
// Configuration registers, stream position counters, window end tracking
// and a two-entry job queue toward the back end.
// ----------------------------------------------------------------------------
module ap2d_front
  import ap2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_sample,
  output cfg_t        cfg_o,
  output logic        job_valid,
  input  logic        job_pop,
  output job_t        job_o
);

  logic [12:0] h_r;
  logic [8:0]  w_r;
  logic [4:0]  ch_r;
  logic [3:0]  wh_r, ww_r, sh_r, sw_r;
  logic [11:0] pads_r;

  logic [12:0] r_r, r_nxt;
  logic [8:0]  x_r, x_nxt;
  logic [4:0]  c_r, c_nxt;
  pos_t        ro_r, ro_nxt, rs_r, rs_nxt, co_r, co_nxt, cs_r, cs_nxt;

  job_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  logic        accept, chan_end, col_end, frame_end;
  logic        row_last, col_last, row_hit, col_hit;
  pos_t        rend, cend;
  cfg_t        cfg;
  job_t        job_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r <= 13'd1; w_r <= 9'd1; ch_r <= 5'd1;
      wh_r <= 4'd1; ww_r <= 4'd1; sh_r <= 4'd1; sw_r <= 4'd1;
      pads_r <= 12'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_HEIGHT:  h_r <= cfg_wdata;
        CFG_IMAGE_WIDTH:   w_r <= cfg_wdata[8:0];
        CFG_CHANNEL_COUNT: ch_r <= cfg_wdata[4:0];
        CFG_WINDOW_HEIGHT: wh_r <= cfg_wdata[3:0];
        CFG_WINDOW_WIDTH:  ww_r <= cfg_wdata[3:0];
        CFG_STRIDE_HEIGHT: sh_r <= cfg_wdata[3:0];
        CFG_STRIDE_WIDTH:  sw_r <= cfg_wdata[3:0];
        CFG_PADS:          pads_r <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.h  = h_r;
    cfg.w  = w_r;
    cfg.ch = ch_r;
    cfg.wh = wh_r;
    cfg.ww = ww_r;
    cfg.sh = sh_r;
    cfg.sw = sw_r;
    cfg.pt = pads_r[11:9];
    cfg.pl = pads_r[5:3];
    cfg.ok = (h_r != 13'd0) && (h_r <= 13'(RowLimit)) && (w_r != 9'd0)
          && (w_r <= 9'(MaxWidth)) && (ch_r != 5'd0) && (ch_r <= 5'(MaxChannels))
          && (wh_r != 4'd0) && (wh_r <= 4'(MaxWindow)) && (ww_r != 4'd0)
          && (ww_r <= 4'(MaxWindow)) && (sh_r != 4'd0) && (sw_r != 4'd0)
          && ({1'b0, pads_r[11:9]} < wh_r) && ({1'b0, pads_r[8:6]} < wh_r)
          && ({1'b0, pads_r[5:3]} < ww_r) && ({1'b0, pads_r[2:0]} < ww_r);
    cfg.trow = pos_t'(h_r) + pos_t'(pads_r[11:9]) + pos_t'(pads_r[8:6]) - pos_t'(wh_r);
    cfg.tcol = pos_t'(w_r) + pos_t'(pads_r[5:3]) + pos_t'(pads_r[2:0]) - pos_t'(ww_r);
  end

  assign cfg_o   = cfg;
  assign in_full = (cnt_r == 2'd2);
  assign accept  = in_push && !in_full;

  always_comb begin
    chan_end  = ({1'b0, c_r} + 6'd1) >= {1'b0, ch_r};
    row_last  = ({1'b0, r_r} + 14'd1) >= {1'b0, h_r};
    col_last  = ({1'b0, x_r} + 10'd1) >= {1'b0, w_r};
    col_end   = chan_end && col_last;
    frame_end = col_end && row_last;
    rend      = rs_r - pos_t'(cfg.pt) + pos_t'(wh_r) - pos_t'(1);
    cend      = cs_r - pos_t'(cfg.pl) + pos_t'(ww_r) - pos_t'(1);
    row_hit   = (pos_t'(r_r) == rend);
    col_hit   = (pos_t'(x_r) == cend);

    job_new.ok        = cfg.ok;
    job_new.frame_end = frame_end;
    job_new.sample    = in_sample;
    job_new.r3        = r_r[2:0];
    job_new.x8        = x_r[7:0];
    job_new.c4        = c_r[3:0];
    job_new.row_multi = row_last;
    job_new.row_any   = (row_last || row_hit) && (rs_r <= cfg.trow);
    job_new.row_o     = ro_r;
    job_new.row_s     = rs_r;
    job_new.col_multi = col_last;
    job_new.col_any   = (col_last || col_hit) && (cs_r <= cfg.tcol);
    job_new.col_o     = co_r;
    job_new.col_s     = cs_r;

    c_nxt  = c_r;
    x_nxt  = x_r;
    r_nxt  = r_r;
    ro_nxt = ro_r;
    rs_nxt = rs_r;
    co_nxt = co_r;
    cs_nxt = cs_r;
    if (accept) begin
      c_nxt = chan_end ? 5'd0 : c_r + 5'd1;
      if (chan_end) x_nxt = col_end ? 9'd0 : x_r + 9'd1;
      if (col_end) r_nxt = frame_end ? 13'd0 : r_r + 13'd1;
      if (col_end) begin
        co_nxt = '0;
        cs_nxt = '0;
      end else if (chan_end && col_hit) begin
        co_nxt = co_r + pos_t'(1);
        cs_nxt = cs_r + pos_t'(sw_r);
      end
      if (frame_end) begin
        ro_nxt = '0;
        rs_nxt = '0;
      end else if (col_end && row_hit) begin
        ro_nxt = ro_r + pos_t'(1);
        rs_nxt = rs_r + pos_t'(sh_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      r_r <= '0; x_r <= '0; c_r <= '0;
      ro_r <= '0; rs_r <= '0; co_r <= '0; cs_r <= '0;
    end else begin
      r_r <= r_nxt; x_r <= x_nxt; c_r <= c_nxt;
      ro_r <= ro_nxt; rs_r <= rs_nxt; co_r <= co_nxt; cs_r <= cs_nxt;
    end
  end

  // job queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (accept) wp_r <= ~wp_r;
      if (job_pop && job_valid) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, accept} - {1'b0, job_pop && job_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) q_r[wp_r] <= job_new;
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job_o     = q_r[rp_r];

endmodule

// File: design/ap2d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ap2d_back
// Line store, window summation, serial divider and result queue.
// ----------------------------------------------------------------------------
module ap2d_back
  import ap2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        job_valid,
  output logic        job_pop,
  input  job_t        job,
  output logic        out_empty,
  input  logic        out_pop,
  output res_t        res_o
);

  logic [15:0]        mem [StoreDepth];
  logic [15:0]        rdata_r;
  logic [StoreAw-1:0] raddr;

  state_t       st_r, st_nxt;
  job_t         job_r, job_nxt;
  pos_t         oy_r, oy_nxt, ys_r, ys_nxt, ox_r, ox_nxt, xs_r, xs_nxt;
  logic [2:0]   ni_r, ni_nxt, nj_r, nj_nxt;
  pos_t         y_r, y_nxt, y1_r, y1_nxt, x0_r, x0_nxt, xx_r, xx_nxt, x1_r, x1_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic signed [21:0] sum_r, sum_nxt;
  logic         neg_r, neg_nxt;
  logic [21:0]  q_r, q_nxt;
  logic [6:0]   rem_r, rem_nxt;
  logic [4:0]   dcnt_r, dcnt_nxt;

  res_t         ofq [4];
  logic [1:0]   owp_r, orp_r;
  logic [2:0]   ocnt_r;
  logic         ofull, opush;
  res_t         res_new;

  logic         col_more, row_more, mem_we;
  pos_t         ya, yb, y0c, y1c, xa, xb, x0c, x1c;
  logic [3:0]   dy, dx;
  logic [7:0]   rem_sh;
  logic signed [21:0] sum_add;

  assign ofull = (ocnt_r == 3'd4);
  assign raddr = {y_r[2:0], xx_r[7:0], job_r.c4};

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          if (!job.ok) st_nxt = S_PUSH;
          else if (job.row_any && job.col_any) st_nxt = S_WIN;
        end
      end
      S_WIN: st_nxt = S_RD;
      S_RD:  st_nxt = S_ACC;
      S_ACC: begin
        if (xx_r + pos_t'(1) == x1_r && y_r + pos_t'(1) == y1_r) st_nxt = S_DIV;
        else st_nxt = S_RD;
      end
      S_DIV: if (dcnt_r == 5'd0) st_nxt = S_PUSH;
      S_PUSH: begin
        if (!ofull) begin
          if (job_r.ok && (col_more || row_more)) st_nxt = S_WIN;
          else st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    job_nxt = job_r;
    oy_nxt = oy_r; ys_nxt = ys_r; ox_nxt = ox_r; xs_nxt = xs_r;
    ni_nxt = ni_r; nj_nxt = nj_r;
    y_nxt = y_r; y1_nxt = y1_r; x0_nxt = x0_r; xx_nxt = xx_r; x1_nxt = x1_r;
    cnt_nxt = cnt_r; sum_nxt = sum_r; neg_nxt = neg_r;
    q_nxt = q_r; rem_nxt = rem_r; dcnt_nxt = dcnt_r;
    job_pop = 1'b0;
    mem_we  = 1'b0;
    opush   = 1'b0;

    ya  = ys_r - pos_t'(cfg.pt);
    yb  = ya + pos_t'(cfg.wh);
    y0c = (ya < 0) ? pos_t'(0) : ya;
    y1c = (yb > pos_t'(cfg.h)) ? pos_t'(cfg.h) : yb;
    xa  = xs_r - pos_t'(cfg.pl);
    xb  = xa + pos_t'(cfg.ww);
    x0c = (xa < 0) ? pos_t'(0) : xa;
    x1c = (xb > pos_t'(cfg.w)) ? pos_t'(cfg.w) : xb;
    dy  = y1c[3:0] - y0c[3:0];
    dx  = x1c[3:0] - x0c[3:0];

    col_more = job_r.col_multi && (nj_r != 3'd7) && (xs_r + pos_t'(cfg.sw) <= cfg.tcol);
    row_more = job_r.row_multi && (ni_r != 3'd7) && (ys_r + pos_t'(cfg.sh) <= cfg.trow);
    rem_sh   = {rem_r, q_r[21]};
    sum_add  = sum_r + 22'(signed'(rdata_r));

    if (job_r.ok) begin
      res_new.average    = neg_r ? 16'(-q_r) : q_r[15:0];
      res_new.row        = oy_r[11:0];
      res_new.col        = ox_r[7:0];
      res_new.chan       = job_r.c4;
      res_new.last       = !(col_more || row_more);
      res_new.frame_done = (ys_r + pos_t'(cfg.sh) > cfg.trow)
                        && (xs_r + pos_t'(cfg.sw) > cfg.tcol)
                        && ({1'b0, job_r.c4} + 5'd1 == cfg.ch);
      res_new.err        = 1'b0;
    end else begin
      res_new.average    = '0;
      res_new.row        = '0;
      res_new.col        = '0;
      res_new.chan       = '0;
      res_new.last       = 1'b1;
      res_new.frame_done = job_r.frame_end;
      res_new.err        = 1'b1;
    end

    case (st_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          mem_we  = job.ok;
          job_nxt = job;
          oy_nxt = job.row_o; ys_nxt = job.row_s; ni_nxt = '0;
          ox_nxt = job.col_o; xs_nxt = job.col_s; nj_nxt = '0;
        end
      end
      S_WIN: begin
        y_nxt = y0c; y1_nxt = y1c;
        x0_nxt = x0c; xx_nxt = x0c; x1_nxt = x1c;
        cnt_nxt = 7'(dy * dx);
        sum_nxt = '0;
      end
      S_ACC: begin
        sum_nxt = sum_add;
        if (xx_r + pos_t'(1) == x1_r) begin
          xx_nxt = x0_r;
          y_nxt  = y_r + pos_t'(1);
        end else begin
          xx_nxt = xx_r + pos_t'(1);
        end
        neg_nxt  = sum_add[21];
        q_nxt    = sum_add[21] ? 22'(-sum_add) : sum_add;
        rem_nxt  = '0;
        dcnt_nxt = 5'd22;
      end
      S_DIV: begin
        if (dcnt_r != 5'd0) begin
          dcnt_nxt = dcnt_r - 5'd1;
          if (rem_sh >= {1'b0, cnt_r}) begin
            rem_nxt = 7'(rem_sh - {1'b0, cnt_r});
            q_nxt   = {q_r[20:0], 1'b1};
          end else begin
            rem_nxt = rem_sh[6:0];
            q_nxt   = {q_r[20:0], 1'b0};
          end
        end
      end
      S_PUSH: begin
        if (!ofull) begin
          opush = 1'b1;
          if (col_more) begin
            ox_nxt = ox_r + pos_t'(1);
            xs_nxt = xs_r + pos_t'(cfg.sw);
            nj_nxt = nj_r + 3'd1;
          end else if (row_more) begin
            oy_nxt = oy_r + pos_t'(1);
            ys_nxt = ys_r + pos_t'(cfg.sh);
            ni_nxt = ni_r + 3'd1;
            ox_nxt = job_r.col_o;
            xs_nxt = job_r.col_s;
            nj_nxt = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    oy_r <= oy_nxt; ys_r <= ys_nxt; ox_r <= ox_nxt; xs_r <= xs_nxt;
    ni_r <= ni_nxt; nj_r <= nj_nxt;
    y_r <= y_nxt; y1_r <= y1_nxt; x0_r <= x0_nxt; xx_r <= xx_nxt; x1_r <= x1_nxt;
    cnt_r <= cnt_nxt; sum_r <= sum_nxt; neg_r <= neg_nxt;
    q_r <= q_nxt; rem_r <= rem_nxt; dcnt_r <= dcnt_nxt;
  end

  // line store
  always_ff @(posedge clk) begin
    if (mem_we) mem[{job.r3, job.x8, job.c4}] <= job.sample;
    rdata_r <= mem[raddr];
  end

  // result queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r <= '0; orp_r <= '0; ocnt_r <= '0;
    end else begin
      if (opush) owp_r <= owp_r + 2'd1;
      if (out_pop && !out_empty) orp_r <= orp_r + 2'd1;
      ocnt_r <= ocnt_r + {2'b0, opush} - {2'b0, out_pop && !out_empty};
    end
  end

  always_ff @(posedge clk) begin
    if (opush) ofq[owp_r] <= res_new;
  end

  assign out_empty = (ocnt_r == 3'd0);
  assign res_o     = ofq[orp_r];

endmodule

// File: design/avg_pool_2d_stream.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// avg_pool_2d_stream
// Streaming 2D average pooling over a Q8.8 feature map, padding excluded.
// ----------------------------------------------------------------------------
// Samples enter in row, column, channel order, one beat per sample, into a
// two-entry job queue; the back end then handles one sample at a time. A
// sample that completes no window is only taken off the queue and written
// into the line store. For each result the back end sets up the window, then
// reads and adds each element of the in-image window (up to 64) in a read
// state and an accumulate state, since the line store has one registered read
// port, runs the 22-step serial divider and pushes the result. Results wait in
// a four-deep output queue. A bad configuration gives one flagged result per
// sample.
module avg_pool_2d_stream
  import ap2d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_wdata,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_sample,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_average,
  output logic [11:0] out_row,
  output logic [7:0]  out_col,
  output logic [3:0]  out_channel,
  output logic        out_last,
  output logic        out_frame_done,
  output logic        out_config_error
);

  cfg_t cfg;
  job_t job;
  logic job_valid, job_pop;
  res_t res;

  ap2d_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_push(in_push), .in_full(in_full), .in_sample(in_sample),
    .cfg_o(cfg), .job_valid(job_valid), .job_pop(job_pop), .job_o(job)
  );

  ap2d_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .job_valid(job_valid), .job_pop(job_pop), .job(job),
    .out_empty(out_empty), .out_pop(out_pop), .res_o(res)
  );

  assign out_average      = res.average;
  assign out_row          = res.row;
  assign out_col          = res.col;
  assign out_channel      = res.chan;
  assign out_last         = res.last;
  assign out_frame_done   = res.frame_done;
  assign out_config_error = res.err;

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty) else $error("result queue not empty after reset");

  a_frame_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_frame_done) |-> out_last)
    else $error("frame end beat not marked last");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_config_error) |-> (out_average == 16'd0 && out_last))
    else $error("error beat carries data");

endmodule
